>>> sv/detector_hit_layer_classifier_unit_macros.svh
// assertion macros for the hit layer classifier
`ifndef DETECTOR_HIT_LAYER_CLASSIFIER_UNIT_MACROS_SVH
`define DETECTOR_HIT_LAYER_CLASSIFIER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DHLC_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define DHLC_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define DHLC_ASSERT_IMP(label, clk, rst, a, c, msg)
`define DHLC_ASSERT_NXT(label, clk, rst, a, c, msg)
`endif
`endif

>>> sv/dhlc_pkg.sv
// package with types and constants of the hit layer classifier
package dhlc_pkg;
  localparam int MaxLayers = 64;
  localparam int CoordWidth = 24;
  localparam int LenWidth = 23;
  localparam int IdxWidth = $clog2(MaxLayers);
  localparam int CntWidth = $clog2(MaxLayers + 1);
  localparam int AddrWidth = IdxWidth + 2;
  localparam int SqWidth = 2 * CoordWidth;
  localparam int RootWidth = CoordWidth;

  localparam logic [2:0] StFound = 3'd0;
  localparam logic [2:0] StBeyondZ = 3'd1;
  localparam logic [2:0] StBeyondR = 3'd2;
  localparam logic [2:0] StNoMatch = 3'd3;
  localparam logic [2:0] StNoRegion = 3'd4;
  localparam logic [2:0] StAppended = 3'd5;
  localparam logic [2:0] StFull = 3'd6;

  localparam logic [2:0] RegEcalBarrelOuterZ = 3'd0;
  localparam logic [2:0] RegEcalEndcapInnerZ = 3'd1;
  localparam logic [2:0] RegHcalBarrelOuterZ = 3'd2;
  localparam logic [2:0] RegMuonBarrelOuterZ = 3'd3;
  localparam logic [2:0] RegMuonEndcapOuterR = 3'd4;
  localparam logic [2:0] RegMuonEndcapLastZ = 3'd5;
  localparam logic [2:0] RegMatchTolerance = 3'd6;

  typedef struct packed {
    logic mode;
    logic [1:0] table_select;
    logic [LenWidth-1:0] layer_radius;
    logic signed [CoordWidth-1:0] hit_x;
    logic signed [CoordWidth-1:0] hit_y;
    logic signed [CoordWidth-1:0] hit_z;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pseudo_layer;
    logic [2:0] status;
  } out_beat_t;

  function automatic logic [CoordWidth-1:0] magnitude(logic [CoordWidth-1:0] v);
    return v[CoordWidth-1] ? (~v + 1'b1) : v;
  endfunction
endpackage

>>> sv/detector_hit_layer_classifier_unit.sv
// top level of the hit layer classifier
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data (mode, select, radius, x, y, z)
// out     | output    | out_valid / out_ready | out_data (pseudo_layer, status)
// cfg     | input     | cfg_we                | cfg_index, cfg_data
// append: result registered on the accepting edge
// classify: iterative square root, then the envelope and upstream tests, then a check per
// region skipped, then a walk over the entries of the matching region
// radii live in one ram of 64 entry banks with one port and a registered read
// synchronous reset clears counts, zone registers and control and sets the tolerance to 13;
// ram contents stay undefined; one item at a time; a result held in the output register stalls the next item
`include "detector_hit_layer_classifier_unit_macros.svh"
module detector_hit_layer_classifier_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dhlc_pkg::in_beat_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dhlc_pkg::out_beat_t           out_data,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [dhlc_pkg::LenWidth-1:0] cfg_data
);
  import dhlc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_SQRT   = 8'b00000010,
    S_RMUON  = 8'b00000100,
    S_RINNER = 8'b00001000,
    S_CHECK  = 8'b00010000,
    S_RLAST  = 8'b00100000,
    S_WALK   = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state;
  logic [LenWidth-1:0] ecal_barrel_outer_z, ecal_endcap_inner_z, hcal_barrel_outer_z;
  logic [LenWidth-1:0] muon_barrel_outer_z, muon_endcap_outer_r, muon_endcap_last_z;
  logic [7:0] match_tolerance;
  logic [CntWidth-1:0] cnt [3];
  logic [CoordWidth-1:0] az;
  logic [RootWidth-1:0] r;
  logic [1:0] region;
  logic [IdxWidth-1:0] idx;
  logic ram_we;
  logic [AddrWidth-1:0] ram_addr;
  logic [LenWidth-1:0] ram_wdata, ram_rdata;
  logic sq_start, sq_done;
  logic [RootWidth-1:0] sq_root;
  logic [CoordWidth-1:0] ax, ay;
  logic [SqWidth-1:0] sq_sum;
  logic [RootWidth+1:0] rw, tw, radw, zw;
  logic [CntWidth-1:0] cur_cnt;
  logic [LenWidth-1:0] cur_zlim;
  logic region_ok, first_ok, near;
  logic [RootWidth+1:0] diff;
  logic [8:0] offset;
  logic [IdxWidth-1:0] idx_last;
  logic walk_ok;
  logic [IdxWidth-1:0] walk_idx;

  assign ax = magnitude(in_data.hit_x);
  assign ay = magnitude(in_data.hit_y);
  assign sq_sum = SqWidth'(ax * ax) + SqWidth'(ay * ay);
  assign sq_start = (state == S_IDLE) && in_valid && in_ready && in_data.mode;

  dhlc_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(sq_sum),
    .done(sq_done), .root(sq_root)
  );

  dhlc_ram #(.Width(LenWidth), .Depth(4 * MaxLayers)) u_radii (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign rw = (RootWidth+2)'(r);
  assign tw = (RootWidth+2)'(match_tolerance);
  assign radw = (RootWidth+2)'(ram_rdata);
  assign zw = (RootWidth+2)'(az);
  assign cur_cnt = cnt[region];
  assign diff = (rw >= radw) ? rw - radw : radw - rw;
  assign near = diff < tw;
  assign idx_last = IdxWidth'(cur_cnt - 1'b1);

  always_comb begin
    case (region)
      2'd0: cur_zlim = ecal_endcap_inner_z;
      2'd1: cur_zlim = hcal_barrel_outer_z;
      default: cur_zlim = muon_barrel_outer_z;
    endcase
    case (region)
      2'd0: offset = 9'd1;
      2'd1: offset = 9'd1 + 9'(cnt[0]);
      default: offset = 9'd1 + 9'(cnt[0]) + 9'(cnt[1]);
    endcase
  end

  // first entry already read; region holds hit if z and first bound pass
  assign first_ok = (zw < (RootWidth+2)'(cur_zlim)) && (rw + tw > radw);
  assign region_ok = rw < radw + tw;

  always_comb begin
    ram_we = 1'b0;
    ram_wdata = in_data.layer_radius;
    ram_addr = {region, idx};
    if (state == S_IDLE && in_valid && in_ready && !in_data.mode) begin
      if (in_data.table_select == 2'd1) ram_addr = {2'd1, cnt[1][IdxWidth-1:0]};
      else if (in_data.table_select == 2'd2) ram_addr = {2'd2, cnt[2][IdxWidth-1:0]};
      else ram_addr = {2'd0, cnt[0][IdxWidth-1:0]};
      ram_we = (in_data.table_select != 2'd3) &&
               (cnt[in_data.table_select == 2'd3 ? 2'd0 : in_data.table_select]
                < CntWidth'(MaxLayers));
    end else if (state == S_SQRT) begin
      ram_addr = {2'd2, IdxWidth'(cnt[2] - 1'b1)};
    end else if (state == S_RMUON) begin
      ram_addr = {2'd0, IdxWidth'(0)};
    end else if (state == S_CHECK) begin
      ram_addr = {region, idx_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt[0] <= '0;
      cnt[1] <= '0;
      cnt[2] <= '0;
      ecal_barrel_outer_z <= '0;
      ecal_endcap_inner_z <= '0;
      hcal_barrel_outer_z <= '0;
      muon_barrel_outer_z <= '0;
      muon_endcap_outer_r <= '0;
      muon_endcap_last_z <= '0;
      match_tolerance <= 8'd13;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegEcalBarrelOuterZ: ecal_barrel_outer_z <= cfg_data;
          RegEcalEndcapInnerZ: ecal_endcap_inner_z <= cfg_data;
          RegHcalBarrelOuterZ: hcal_barrel_outer_z <= cfg_data;
          RegMuonBarrelOuterZ: muon_barrel_outer_z <= cfg_data;
          RegMuonEndcapOuterR: muon_endcap_outer_r <= cfg_data;
          RegMuonEndcapLastZ: muon_endcap_last_z <= cfg_data;
          RegMatchTolerance: match_tolerance <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            out_data.pseudo_layer <= 8'd0;
            if (!in_data.mode) begin
              out_valid <= 1'b1;
              if (ram_we) begin
                out_data.status <= StAppended;
                cnt[in_data.table_select] <= cnt[in_data.table_select] + 1'b1;
              end else begin
                out_data.status <= StFull;
              end
            end else begin
              az <= magnitude(in_data.hit_z);
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            r <= sq_root;
            state <= S_RMUON;
          end
        end
        S_RMUON: begin
          // ram now holds last muon radius
          region <= 2'd0;
          idx <= '0;
          if ((RootWidth+2)'(az) > (RootWidth+2)'(muon_endcap_last_z) + tw) begin
            out_data.status <= StBeyondZ;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if ((cnt[2] == '0 || rw > radw + tw) &&
                       rw > (RootWidth+2)'(muon_endcap_outer_r)) begin
            out_data.status <= StBeyondR;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_RINNER;
          end
        end
        S_RINNER: begin
          // ram holds inner first radius
          if (cnt[0] != '0 && rw + tw < radw &&
              zw < (RootWidth+2)'(ecal_barrel_outer_z)) begin
            out_data.status <= StFound;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // ram holds first radius of region
          if (cur_cnt != '0 && first_ok) begin
            idx <= idx_last;
            state <= S_RLAST;
          end else if (region == 2'd2) begin
            out_data.status <= StNoRegion;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            region <= region + 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for the read of the first radius of the next region
          idx <= '0;
          state <= S_CHECK;
        end
        S_RLAST: begin
          // waits read of last radius
          idx <= '0;
          state <= S_WALK;
          if (!region_ok) begin
            if (region == 2'd2) begin
              out_data.status <= StNoRegion;
              out_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              region <= region + 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_WALK: begin
          // ram output lags idx by its registered read; the lagged index walk_idx names the entry shown
          if (near && walk_ok) begin
            out_data.status <= StFound;
            out_data.pseudo_layer <= 8'(offset + 9'(walk_idx));
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (walk_ok && walk_idx == idx_last) begin
            out_data.status <= StNoMatch;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else if (idx != idx_last) begin
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // lagged index tracks the entry whose data the ram presents
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_ok <= 1'b0;
    end else begin
      walk_ok <= (state == S_WALK) && !(out_valid);
      if (state != S_WALK) walk_ok <= 1'b0;
    end
    walk_idx <= idx;
  end

  `DHLC_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE, "ready outside idle")
  `DHLC_ASSERT_IMP(a_cnt_max, clk, rst, 1'b1, cnt[2] <= CntWidth'(MaxLayers), "count overflow")
  `DHLC_ASSERT_NXT(a_append_one, clk, rst,
    in_valid && in_ready && !in_data.mode, out_valid, "append gave no beat")
endmodule

>>> sv/dhlc_ram.sv
// generic single port ram with registered read
module dhlc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/dhlc_isqrt.sv
// iterative integer square root, one result bit per cycle
module dhlc_isqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dhlc_pkg::SqWidth-1:0]   radicand,
  output logic                           done,
  output logic [dhlc_pkg::RootWidth-1:0] root
);
  import dhlc_pkg::*;
  localparam int StepWidth = $clog2(RootWidth + 1);
  logic [SqWidth-1:0] rem;
  logic [SqWidth-1:0] num;
  logic [RootWidth-1:0] res;
  logic [StepWidth-1:0] steps;
  logic busy;
  logic [SqWidth+1:0] trial;
  logic [SqWidth+1:0] rem_sh;

  always_comb begin
    rem_sh = {rem, num[SqWidth-1:SqWidth-2]};
    trial = {{(SqWidth+2-RootWidth-2){1'b0}}, res, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= StepWidth'(RootWidth);
        rem <= '0;
        res <= '0;
        num <= radicand;
      end else if (busy) begin
        num <= num << 2;
        if (rem_sh >= trial) begin
          rem <= SqWidth'(rem_sh - trial);
          res <= {res[RootWidth-2:0], 1'b1};
        end else begin
          rem <= SqWidth'(rem_sh);
          res <= {res[RootWidth-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == StepWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign root = res;
endmodule

>>> tb/sv/tb.sv
// testbench for the hit layer classifier: directed table, then random beats checked by a predictor
`timescale 1ns / 100ps
module tb;
  import dhlc_pkg::*;

  localparam int HangLimit = 20000;

  typedef struct {
    logic mode;
    logic [1:0] sel;
    logic [22:0] rad;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    bit known;
    logic [7:0] layer;
    logic [2:0] st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;

  detector_hit_layer_classifier_unit i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the block state
  logic [22:0] radii [3][MaxLayers];
  int unsigned fill [3];
  logic [22:0] zreg [6];
  logic [7:0] tol;

  out_beat_t layer_queue [$];
  int mismatches = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_found = 0;
  int idle_cnt = 0;
  bit stim_done = 1'b0;
  row_t dir_rows [$];

  function automatic longint unsigned mag(logic [23:0] v);
    return v[23] ? longint'(~v + 24'd1) & 64'hFFFFFF : longint'(v);
  endfunction

  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned lo = 0, hi = 64'd16777216, mid;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // 0 found, 1 not held, 2 no match
  function automatic int search_bank(int b, longint unsigned r, longint unsigned z,
                                     longint unsigned zlim, output int idx);
    longint unsigned t = tol, d;
    idx = 0;
    if (fill[b] == 0) return 1;
    if (!(z < zlim && r + t > radii[b][0] && r < radii[b][fill[b]-1] + t)) return 1;
    for (int i = 0; i < fill[b]; i++) begin
      d = (r >= radii[b][i]) ? r - radii[b][i] : radii[b][i] - r;
      if (d < t) begin
        idx = i;
        return 0;
      end
    end
    return 2;
  endfunction

  function automatic out_beat_t classify_hit(in_beat_t b);
    out_beat_t o;
    longint unsigned ax, ay, z, r, t;
    longint unsigned off;
    bit rout;
    int res, idx;
    o = '0;
    if (!b.mode) begin
      if (b.table_select != 2'd3 && fill[b.table_select] < MaxLayers) begin
        radii[b.table_select][fill[b.table_select]] = b.layer_radius;
        fill[b.table_select]++;
        o.status = StAppended;
      end else o.status = StFull;
      return o;
    end
    t = tol;
    ax = mag(b.hit_x);
    ay = mag(b.hit_y);
    z = mag(b.hit_z);
    r = root_of(ax * ax + ay * ay);
    rout = (fill[2] == 0) ? 1'b1 : (r > radii[2][fill[2]-1] + t);
    if (z > zreg[RegMuonEndcapLastZ] + t) o.status = StBeyondZ;
    else if (rout && r > zreg[RegMuonEndcapOuterR]) o.status = StBeyondR;
    else if (fill[0] != 0 && r + t < radii[0][0] && z < zreg[RegEcalBarrelOuterZ])
      o.status = StFound;
    else begin
      o.status = StNoRegion;
      off = 0;
      for (int k = 0; k < 3; k++) begin
        res = search_bank(k, r, z, zreg[RegEcalEndcapInnerZ + k], idx);
        if (res != 1) begin
          o.status = (res == 0) ? StFound : StNoMatch;
          if (res == 0) o.pseudo_layer = 8'(1 + off + idx);
          break;
        end
        off += fill[k];
      end
    end
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegMatchTolerance) tol = val[7:0];
    else zreg[idx] = val;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (layer_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send_hit(in_beat_t b, bit known, out_beat_t want);
    out_beat_t p;
    int gap;
    gap = $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = classify_hit(b);
    if (known && p != want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table entry disagrees: %0d/%0d vs %0d/%0d",
                 want.pseudo_layer, want.status, p.pseudo_layer, p.status);
    end
    layer_queue.insert(layer_queue.size(), p);
    n_sent++;
  endtask

  always @(posedge clk) begin
    out_beat_t w;
    if (!rst) begin
      if (out_valid && out_ready) begin
        n_got++;
        if (layer_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          w = layer_queue.pop_front();
          if (w.status == StFound && out_data.status == StFound) n_found++;
          if (w.pseudo_layer !== out_data.pseudo_layer || w.status !== out_data.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: layer exp %0d got %0d, status exp %0d got %0d",
                       w.pseudo_layer, out_data.pseudo_layer, w.status, out_data.status);
          end
        end
      end
    end
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
      end else if (!out_ready) out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || stim_done) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= HangLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_beat_t mk(logic m, logic [1:0] s, logic [22:0] rd,
                                  logic [23:0] x, logic [23:0] y, logic [23:0] z);
    in_beat_t b;
    b.mode = m;
    b.table_select = s;
    b.layer_radius = rd;
    b.hit_x = x;
    b.hit_y = y;
    b.hit_z = z;
    return b;
  endfunction

  function automatic logic [23:0] rnd_coord(int unsigned lim);
    logic [23:0] v;
    v = 24'($urandom_range(0, lim));
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic build_tables(int unsigned base, int unsigned step, int unsigned per);
    logic [22:0] r;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < per; i++) begin
        r = 23'(base + (k * per + i) * step + $urandom_range(0, step / 4));
        send_hit(mk(1'b0, 2'(k), r, '0, '0, '0), 1'b0, '0);
      end
    end
  endtask

  initial begin
    in_beat_t b;
    out_beat_t w;
    int unsigned lim, pk, per, step;
    for (int k = 0; k < 3; k++) fill[k] = 0;
    for (int k = 0; k < 6; k++) zreg[k] = '0;
    tol = 8'd13;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: after reset every hit is beyond or empty, then append beats follow
    dir_rows.insert(dir_rows.size(),
      row_t'{1'b1, 2'd0, 23'd0, 24'd0, 24'd0, 24'd0, 1'b1, 8'd0, StNoRegion});
    dir_rows.insert(dir_rows.size(),
      row_t'{1'b1, 2'd0, 23'd0, 24'd0, 24'd0, 24'd14, 1'b1, 8'd0, StBeyondZ});
    dir_rows.insert(dir_rows.size(),
      row_t'{1'b1, 2'd0, 23'd0, 24'd1, 24'd0, 24'd0, 1'b1, 8'd0, StBeyondR});
    dir_rows.insert(dir_rows.size(),
      row_t'{1'b1, 2'd0, 23'd0, 24'h800000, 24'h800000, 24'h800000,
             1'b1, 8'd0, StBeyondZ});
    dir_rows.insert(dir_rows.size(),
      row_t'{1'b0, 2'd3, 23'h7FFFFF, 24'd0, 24'd0, 24'd0, 1'b1, 8'd0, StFull});
    dir_rows.insert(dir_rows.size(),
      row_t'{1'b0, 2'd0, 23'd2560, 24'd0, 24'd0, 24'd0, 1'b1, 8'd0, StAppended});
    dir_rows.insert(dir_rows.size(),
      row_t'{1'b0, 2'd1, 23'd5120, 24'd0, 24'd0, 24'd0, 1'b1, 8'd0, StAppended});
    dir_rows.insert(dir_rows.size(),
      row_t'{1'b0, 2'd2, 23'h7FFFFF, 24'd0, 24'd0, 24'd0, 1'b1, 8'd0, StAppended});
    foreach (dir_rows[i]) begin
      b = mk(dir_rows[i].mode, dir_rows[i].sel, dir_rows[i].rad,
             dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
      w.pseudo_layer = dir_rows[i].layer;
      w.status = dir_rows[i].st;
      send_hit(b, dir_rows[i].known, w);
    end
    drain_results();

    write_reg(RegEcalBarrelOuterZ, 23'd1000);
    write_reg(RegEcalEndcapInnerZ, 23'd3000);
    write_reg(RegHcalBarrelOuterZ, 23'd6000);
    write_reg(RegMuonBarrelOuterZ, 23'h7FFFFF);
    write_reg(RegMuonEndcapOuterR, 23'h7FFFFF);
    write_reg(RegMuonEndcapLastZ, 23'h7FFFFF);
    write_reg(RegMatchTolerance, 23'd255);
    send_hit(mk(1'b1, 2'd0, '0, 24'd2560, 24'd0, 24'd0), 1'b1, '{8'd1, StFound});
    send_hit(mk(1'b1, 2'd0, '0, 24'd5120, 24'd0, 24'd4000), 1'b1, '{8'd2, StFound});
    send_hit(mk(1'b1, 2'd0, '0, 24'd10, 24'd0, 24'd10), 1'b1, '{8'd0, StFound});
    send_hit(mk(1'b1, 2'd0, '0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF), 1'b1,
             '{8'd0, StBeyondR});
    send_hit(mk(1'b1, 2'd0, '0, 24'h800000, 24'd0, 24'd9000), 1'b0, '0);
    send_hit(mk(1'b1, 2'd0, '0, 24'd4000, 24'd3000, 24'h800000), 1'b0, '0);
    send_hit(mk(1'b1, 2'd0, '0, 24'd4000, 24'd0, 24'd100), 1'b0, '0);
    // fill the muon table to its end
    for (int i = 1; i < MaxLayers; i++)
      send_hit(mk(1'b0, 2'd2, 23'h7FFFFF, '0, '0, '0), 1'b0, '0);
    send_hit(mk(1'b0, 2'd2, 23'd1, '0, '0, '0), 1'b1, '{8'd0, StFull});
    drain_results();

    // random phases, each after a reset of the tables is not possible, so tables keep
    // growing until full; settings vary per phase
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      step = $urandom_range(200, 3000);
      write_reg(RegMatchTolerance, (ph == 1) ? 23'd0 : (ph == 2) ? 23'd255
                                   : 23'($urandom_range(1, 255)));
      write_reg(RegEcalBarrelOuterZ, 23'($urandom_range(0, 40000)));
      write_reg(RegEcalEndcapInnerZ, 23'($urandom_range(0, 80000)));
      write_reg(RegHcalBarrelOuterZ, 23'($urandom_range(0, 160000)));
      write_reg(RegMuonBarrelOuterZ, (ph == 3) ? 23'h7FFFFF : 23'($urandom_range(0, 300000)));
      write_reg(RegMuonEndcapOuterR, (ph == 4) ? 23'd0 : 23'($urandom_range(0, 400000)));
      write_reg(RegMuonEndcapLastZ, (ph == 5) ? 23'd0 : 23'($urandom_range(0, 400000)));
      per = $urandom_range(1, 6);
      build_tables($urandom_range(0, 20000), step, per);
      lim = 200000;
      for (int i = 0; i < 160; i++) begin
        pk = $urandom_range(0, 99);
        if (pk < 4) b = mk(1'b0, 2'($urandom_range(0, 3)), 23'($urandom), '0, '0, '0);
        else if (pk < 10) b = mk(1'b1, '0, '0, 24'($urandom), 24'($urandom), 24'($urandom));
        else b = mk(1'b1, 2'($urandom), 23'($urandom), rnd_coord(lim / 2),
                    rnd_coord(lim / 2), rnd_coord(lim));
        send_hit(b, 1'b0, '0);
        if (i == 80) drain_results();
      end
    end
    drain_results();
    stim_done = 1'b1;
    $display("sent %0d beats, got %0d results, %0d of them layered hits",
             n_sent, n_got, n_found);
    if (mismatches == 0 && layer_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, layer_queue.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
